>>> src/dedup_hash_set_counter_macros.svh
// Assertion macros for the dedup hash set counter.
// Included by the top level; no other dependencies.
`ifndef DEDUP_HASH_SET_COUNTER_MACROS_SVH
`define DEDUP_HASH_SET_COUNTER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DHSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define DHSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DHSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define DHSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> src/dhsc_pkg.sv
// Package for the dedup hash set counter: widths, constants, codes and types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dhsc_pkg;

   localparam int TABLE_BITS_DEFAULT = 10;
   localparam int KEY_W              = 64;
   localparam int HALF_W             = 32;
   localparam int COUNT_W            = 32;
   localparam int TOTAL_W            = 11;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [KEY_W-1:0]   HASH_MUL  = 64'd1181783497276652981;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_CLEAR  = 1'b1
   } dhsc_action_type;

   // one classified item between front and back
   typedef struct packed {
      dhsc_action_type     action;
      logic [KEY_W-1:0]    key;
      logic [HALF_W-1:0]   hash_hi;
   } dhsc_item_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL0,
      F_MUL1,
      F_MUL2,
      F_PUSH
   } dhsc_front_state_type;

   typedef enum logic [1:0] {
      B_SWEEP,
      B_IDLE,
      B_CHECK,
      B_CLR_RESP
   } dhsc_back_state_type;

endpackage

>>> src/dedup_hash_set_counter.sv
// Top level of the dedup hash set counter: front, queue and back.
// Depends on dhsc_pkg, dhsc_front, dhsc_queue, dhsc_back and the macros header.
`timescale 1ns / 1ps
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_ready  action, key
//   rsp       out         rsp_valid/rsp_ready  is_new, occurrences, unique_count, table_full
//
// An insert passes the front as accept, three steps of the shared 32x32 hash
// multiplier and push, and the back as a walk of p slots, one registered memory
// read per slot; the queue lets both run at once.
// A clear sweeps all 2^TABLE_BITS slots, one per cycle, then reports.
// After reset the same sweep runs over all slots with req_ready low.
// A stalled result holds the back at its final step; the front keeps filling the queue.

`include "dedup_hash_set_counter_macros.svh"

module dedup_hash_set_counter #(
   parameter int TABLE_BITS = dhsc_pkg::TABLE_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_action,
   input  logic [63:0]  req_key,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_is_new,
   output logic [31:0]  rsp_occurrences,
   output logic [10:0]  rsp_unique_count,
   output logic         rsp_table_full
);
   import dhsc_pkg::*;

   logic            q_push_valid, q_push_ready;
   dhsc_item_type   q_push_item;
   logic            q_pop_valid, q_pop_ready;
   dhsc_item_type   q_pop_item;
   logic            sweep_busy;

   // hash front
   dhsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (!sweep_busy),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_key    (req_key),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item)
   );

   // decoupling queue
   dhsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   // probe back end
   dhsc_back #(
      .TABLE_BITS (TABLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (q_pop_valid),
      .pop_ready        (q_pop_ready),
      .pop_item         (q_pop_item),
      .sweep_busy       (sweep_busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_new       (rsp_is_new),
      .rsp_occurrences  (rsp_occurrences),
      .rsp_unique_count (rsp_unique_count),
      .rsp_table_full   (rsp_table_full)
   );

   // checks
   `DHSC_ASSERT_IMPLY(a_full_no_count, clock, reset, rsp_valid && rsp_table_full, (rsp_occurrences == 32'd0) && !rsp_is_new, "full result carries a count")
   `DHSC_ASSERT_IMPLY(a_new_count_one, clock, reset, rsp_valid && rsp_is_new, (rsp_occurrences == 32'd1) && !rsp_table_full, "new key result malformed")
   `DHSC_ASSERT_IMPLY(a_sweep_blocks_req, clock, reset, sweep_busy, !req_ready, "transfer accepted during sweep")
   `DHSC_ASSERT_NEXT(a_push_holds, clock, reset, q_push_valid && !q_push_ready, q_push_valid && (q_push_item == $past(q_push_item)), "stalled queue push changed")

endmodule

>>> src/dhsc_front.sv
// Front end: accepts items, maps key zero to one and hashes the key of each insert.
// Depends on dhsc_pkg; feeds dhsc_queue.
`timescale 1ns / 1ps

module dhsc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic [63:0]                req_key,
   output logic                       push_valid,
   input  logic                       push_ready,
   output dhsc_pkg::dhsc_item_type    push_item
);
   import dhsc_pkg::*;

   dhsc_front_state_type state_ff, state_in;
   dhsc_action_type      action_ff, action_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [HALF_W-1:0]    hi0_ff, hi0_in;
   logic [HALF_W-1:0]    cross1_ff, cross1_in;
   logic [HALF_W-1:0]    cross2_ff, cross2_in;
   logic [HALF_W-1:0]    mul_a, mul_b;
   logic [KEY_W-1:0]     product;
   logic                 accept;

   // shared 32x32 multiplier, one partial product per cycle
   always_comb begin
      unique case (state_ff)
         F_MUL1: begin
            mul_a = key_ff[KEY_W-1:HALF_W];
            mul_b = HASH_MUL[HALF_W-1:0];
         end
         F_MUL2: begin
            mul_a = key_ff[HALF_W-1:0];
            mul_b = HASH_MUL[KEY_W-1:HALF_W];
         end
         default: begin
            mul_a = key_ff[HALF_W-1:0];
            mul_b = HASH_MUL[HALF_W-1:0];
         end
      endcase
   end

   assign product = 64'(mul_a) * 64'(mul_b);
   assign accept  = req_valid && req_ready;

   // next state and handshake
   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      key_in     = key_ff;
      hi0_in     = hi0_ff;
      cross1_in  = cross1_ff;
      cross2_in  = cross2_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = enable;
         end
         F_MUL0: begin
            hi0_in   = product[KEY_W-1:HALF_W];
            state_in = F_MUL1;
         end
         F_MUL1: begin
            cross1_in = product[HALF_W-1:0];
            state_in  = F_MUL2;
         end
         F_MUL2: begin
            cross2_in = product[HALF_W-1:0];
            state_in  = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               req_ready = enable;
               state_in  = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      // new transfer, clear skips the hash
      if (accept) begin
         action_in = dhsc_action_type'(req_action);
         key_in    = (req_key == 64'd0) ? 64'd1 : req_key;
         state_in  = (dhsc_action_type'(req_action) == ACT_CLEAR) ? F_PUSH : F_MUL0;
      end
   end

   // top word of key times multiplier, mod 2^64
   always_comb begin
      push_item.action  = action_ff;
      push_item.key     = key_ff;
      push_item.hash_hi = hi0_ff + cross1_ff + cross2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      key_ff    <= key_in;
      hi0_ff    <= hi0_in;
      cross1_ff <= cross1_in;
      cross2_ff <= cross2_in;
   end

endmodule

>>> src/dhsc_queue.sv
// Short queue of classified items between front and back.
// Depends on dhsc_pkg.
`timescale 1ns / 1ps

module dhsc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  dhsc_pkg::dhsc_item_type    push_item,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output dhsc_pkg::dhsc_item_type    pop_item
);
   import dhsc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   dhsc_item_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/dhsc_back.sv
// Back end: slot memories, linear probe walk, clearing sweep and result register.
// Depends on dhsc_pkg; takes items from dhsc_queue.
`timescale 1ns / 1ps

module dhsc_back #(
   parameter int TABLE_BITS = dhsc_pkg::TABLE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  dhsc_pkg::dhsc_item_type    pop_item,
   output logic                       sweep_busy,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_is_new,
   output logic [31:0]                rsp_occurrences,
   output logic [10:0]                rsp_unique_count,
   output logic                       rsp_table_full
);
   import dhsc_pkg::*;

   localparam int SLOTS = 1 << TABLE_BITS;
   localparam logic [TABLE_BITS-1:0] IDX_LAST = '1;

   // slot memories
   logic [KEY_W-1:0]      slot_key_ff [SLOTS];
   logic [COUNT_W-1:0]    slot_cnt_ff [SLOTS];
   logic [KEY_W-1:0]      rd_key_ff;
   logic [COUNT_W-1:0]    rd_cnt_ff;
   logic                  rd_en;
   logic [TABLE_BITS-1:0] rd_addr;
   logic                  key_wr_en, cnt_wr_en;
   logic [KEY_W-1:0]      slot_key_in;
   logic [COUNT_W-1:0]    slot_cnt_in;

   dhsc_back_state_type   state_ff, state_in;
   logic [TABLE_BITS-1:0] idx_ff, idx_in;
   logic [TABLE_BITS-1:0] probe_ff, probe_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic                  clr_pending_ff, clr_pending_in;
   logic [TOTAL_W-1:0]    distinct_ff, distinct_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_new_ff, rsp_new_in;
   logic [COUNT_W-1:0]    rsp_occ_ff, rsp_occ_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  rsp_load;

   logic                  out_free, slot_empty, slot_match;
   logic [TABLE_BITS-1:0] idx_next;
   logic [COUNT_W-1:0]    cnt_next;
   logic [TOTAL_W-1:0]    distinct_next;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign slot_empty    = (rd_key_ff == '0);
   assign slot_match    = (rd_key_ff == key_ff);
   assign idx_next      = idx_ff + TABLE_BITS'(1);
   assign cnt_next      = (rd_cnt_ff == COUNT_MAX) ? rd_cnt_ff : rd_cnt_ff + COUNT_W'(1);
   assign distinct_next = (distinct_ff == TOTAL_MAX) ? distinct_ff
                                                     : distinct_ff + TOTAL_W'(1);
   assign sweep_busy    = (state_ff == B_SWEEP);

   // probe sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      probe_in       = probe_ff;
      key_in         = key_ff;
      clr_pending_in = clr_pending_ff;
      distinct_in    = distinct_ff;
      pop_ready      = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = idx_next;
      key_wr_en      = 1'b0;
      cnt_wr_en      = 1'b0;
      slot_key_in    = key_ff;
      slot_cnt_in    = cnt_next;
      rsp_load       = 1'b0;
      rsp_new_in     = 1'b0;
      rsp_occ_in     = '0;
      rsp_total_in   = distinct_ff;
      rsp_full_in    = 1'b0;
      unique case (state_ff)
         B_SWEEP: begin
            // one slot emptied per cycle
            key_wr_en   = 1'b1;
            slot_key_in = '0;
            idx_in      = idx_next;
            if (idx_ff == IDX_LAST) begin
               state_in = clr_pending_ff ? B_CLR_RESP : B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               if (pop_item.action == ACT_CLEAR) begin
                  clr_pending_in = 1'b1;
                  distinct_in    = '0;
                  idx_in         = '0;
                  state_in       = B_SWEEP;
               end else begin
                  // read the home slot
                  rd_en    = 1'b1;
                  rd_addr  = pop_item.hash_hi[HALF_W-1 -: TABLE_BITS];
                  idx_in   = pop_item.hash_hi[HALF_W-1 -: TABLE_BITS];
                  probe_in = '0;
                  key_in   = pop_item.key;
                  state_in = B_CHECK;
               end
            end
         end
         B_CHECK: begin
            priority if (slot_empty) begin
               // absent key takes the first empty slot
               if (out_free) begin
                  key_wr_en    = 1'b1;
                  cnt_wr_en    = 1'b1;
                  slot_cnt_in  = COUNT_W'(1);
                  distinct_in  = distinct_next;
                  rsp_load     = 1'b1;
                  rsp_new_in   = 1'b1;
                  rsp_occ_in   = COUNT_W'(1);
                  rsp_total_in = distinct_next;
                  state_in     = B_IDLE;
               end
            end else if (slot_match) begin
               // present key, saturating count
               if (out_free) begin
                  cnt_wr_en  = 1'b1;
                  rsp_load   = 1'b1;
                  rsp_occ_in = cnt_next;
                  state_in   = B_IDLE;
               end
            end else if (probe_ff == IDX_LAST) begin
               // every slot visited, nothing stored
               if (out_free) begin
                  rsp_load    = 1'b1;
                  rsp_full_in = 1'b1;
                  state_in    = B_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               idx_in   = idx_next;
               probe_in = probe_ff + TABLE_BITS'(1);
            end
         end
         B_CLR_RESP: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               clr_pending_in = 1'b0;
               state_in       = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_SWEEP;
         idx_ff         <= '0;
         clr_pending_ff <= 1'b0;
         distinct_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         clr_pending_ff <= clr_pending_in;
         distinct_ff    <= distinct_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      key_ff   <= key_in;
      if (rsp_load) begin
         rsp_new_ff   <= rsp_new_in;
         rsp_occ_ff   <= rsp_occ_in;
         rsp_total_ff <= rsp_total_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   // memory write port and registered read port
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         slot_key_ff[idx_ff] <= slot_key_in;
      end
      if (cnt_wr_en) begin
         slot_cnt_ff[idx_ff] <= slot_cnt_in;
      end
      if (rd_en) begin
         rd_key_ff <= slot_key_ff[rd_addr];
         rd_cnt_ff <= slot_cnt_ff[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_occurrences  = rsp_occ_ff;
   assign rsp_unique_count = rsp_total_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the dedup hash set counter: random and directed
// inserts and clears, checked against an in-bench model of the probing table.
// Depends on dhsc_pkg and the dedup_hash_set_counter top level.
`timescale 1ns / 1ps

module testbench;
   import dhsc_pkg::*;

   localparam int SLOT_BITS      = TABLE_BITS_DEFAULT;
   localparam int SLOTS          = 1 << SLOT_BITS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic               is_new;
      logic [COUNT_W-1:0] occurrences;
      logic [TOTAL_W-1:0] unique_count;
      logic               table_full;
   } hash_result_type;

   // keeps its own copy of the table and the results still owed by the block
   class hash_set_tracker;
      logic [KEY_W-1:0]   slot_key  [SLOTS];
      logic [COUNT_W-1:0] slot_hits [SLOTS];
      logic [TOTAL_W-1:0] distinct;
      hash_result_type    awaited [$];
      int unsigned        mismatches;

      function new();
         wipe();
         mismatches = 0;
      endfunction

      function void wipe();
         foreach (slot_key[i]) begin
            slot_key[i]  = '0;
            slot_hits[i] = '0;
         end
         distinct = '0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // work out the result of one accepted request transfer
      function void note_request(logic action, logic [KEY_W-1:0] key);
         hash_result_type  r;
         logic [KEY_W-1:0] k;
         logic [KEY_W-1:0] h;
         int unsigned      idx;
         int unsigned      n;
         bit               done;
         r = '0;
         if (action == ACT_CLEAR) begin
            wipe();
         end else begin
            k    = (key == '0) ? 64'd1 : key;
            h    = (k * HASH_MUL) >> (KEY_W - SLOT_BITS);
            idx  = int'(h);
            done = 1'b0;
            // linear walk with wrap, at most one visit per slot
            for (n = 0; n < SLOTS && !done; n++) begin
               if (slot_key[idx] == '0) begin
                  slot_key[idx]  = k;
                  slot_hits[idx] = 1;
                  if (distinct < TOTAL_MAX) distinct++;
                  r.is_new      = 1'b1;
                  r.occurrences = 1;
                  done          = 1'b1;
               end else if (slot_key[idx] == k) begin
                  if (slot_hits[idx] != COUNT_MAX) slot_hits[idx]++;
                  r.occurrences = slot_hits[idx];
                  done          = 1'b1;
               end else begin
                  idx = (idx + 1) % SLOTS;
               end
            end
            r.table_full = !done;
         end
         r.unique_count = distinct;
         awaited.push_back(r);
      endfunction

      // compare one result transfer with the oldest owed result
      function void check_response(logic is_new, logic [COUNT_W-1:0] occurrences,
                                   logic [TOTAL_W-1:0] unique_count, logic table_full);
         hash_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with none outstanding: is_new %0d occ %0d uniq %0d full %0d",
                        $realtime, is_new, occurrences, unique_count, table_full);
         end else begin
            want = awaited.pop_front();
            if (is_new !== want.is_new || occurrences !== want.occurrences ||
                unique_count !== want.unique_count || table_full !== want.table_full) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("%0t: mismatch (expected/actual): is_new %0d/%0d occ %0d/%0d",
                         $realtime, want.is_new, is_new, want.occurrences, occurrences);
                  $display(" uniq %0d/%0d full %0d/%0d",
                           want.unique_count, unique_count, want.table_full, table_full);
               end
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic [KEY_W-1:0]   req_key;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_is_new;
   logic [COUNT_W-1:0] rsp_occurrences;
   logic [TOTAL_W-1:0] rsp_unique_count;
   logic               rsp_table_full;

   hash_set_tracker    tracker;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;
   bit                 hold_pending;
   logic [KEY_W-1:0]   key_pool [$];

   dedup_hash_set_counter #(.TABLE_BITS(SLOT_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_new       (rsp_is_new),
      .rsp_occurrences  (rsp_occurrences),
      .rsp_unique_count (rsp_unique_count),
      .rsp_table_full   (rsp_table_full)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // key whose home slot is the given one, built with the multiplier's inverse
   function automatic logic [KEY_W-1:0] key_for_slot(int unsigned slot, logic [KEY_W-1:0] low);
      logic [KEY_W-1:0] inv;
      logic [KEY_W-1:0] prod;
      int               i;
      inv = HASH_MUL;
      for (i = 0; i < 6; i++) inv = inv * (64'd2 - HASH_MUL * inv);
      prod = (64'(slot) << (KEY_W - SLOT_BITS)) |
             (low & ((64'd1 << (KEY_W - SLOT_BITS)) - 64'd1)) | 64'd1;
      return inv * prod;
   endfunction

   // offer one request, with random idle cycles ahead of it
   task automatic send_item(dhsc_action_type act, logic [KEY_W-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid  <= 1'b0;
         req_action <= 1'($urandom_range(1));
         req_key    <= {$urandom, $urandom};
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // random request: repeats, colliding keys, keys zero and one, fresh keys, some clears
   task automatic send_random();
      int unsigned      pick;
      int unsigned      hot;
      logic [KEY_W-1:0] k;
      pick = $urandom_range(99);
      if (pick < 2) begin
         send_item(ACT_CLEAR, {$urandom, $urandom});
      end else begin
         if (pick < 32 && key_pool.size() > 0) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
         end else if (pick < 52) begin
            case ($urandom_range(2))
               0: hot = 0;
               1: hot = SLOTS - 1;
               default: hot = $urandom_range(SLOTS - 1);
            endcase
            k = key_for_slot(hot, {$urandom, $urandom});
         end else if (pick < 57) begin
            k = 64'($urandom_range(1));
         end else begin
            k = {$urandom, $urandom};
         end
         key_pool.push_back(k);
         if (key_pool.size() > 64) void'(key_pool.pop_front());
         send_item(ACT_INSERT, k);
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // note every transfer on both channels
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid === 1'b1 && req_ready === 1'b1)
            tracker.note_request(req_action, req_key);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            tracker.check_response(rsp_is_new, rsp_occurrences, rsp_unique_count,
                                   rsp_table_full);
      end
   end

   // end the run after too long without any transfer
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [KEY_W-1:0] wrap_key;
      logic [KEY_W-1:0] kept_key;
      int unsigned      i;
      int unsigned      ph;
      tracker       = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_INSERT;
      req_key       = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_pending  = 1'b0;
      wrap_key      = '0;
      kept_key      = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero and one are the same entry, then extreme keys
      send_item(ACT_INSERT, 64'd0);
      send_item(ACT_INSERT, 64'd1);
      send_item(ACT_INSERT, '1);
      send_item(ACT_INSERT, '1);
      send_item(ACT_INSERT, 64'h8000_0000_0000_0000);
      send_item(ACT_INSERT, 64'h5555_5555_5555_5555);
      send_item(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
      // chain homed at the last slot wraps around to the first ones
      for (i = 0; i < 3; i++) begin
         wrap_key = key_for_slot(SLOTS - 1, {$urandom, $urandom});
         send_item(ACT_INSERT, wrap_key);
      end
      send_item(ACT_INSERT, key_for_slot(0, {$urandom, $urandom}));
      send_item(ACT_INSERT, wrap_key);
      // clear, clear of an empty table, then reuse
      send_item(ACT_CLEAR, '1);
      send_item(ACT_CLEAR, '0);
      send_item(ACT_INSERT, 64'd0);
      send_item(ACT_INSERT, wrap_key);
      send_item(ACT_CLEAR, '0);

      // fill every slot at its home, then hit the full table
      send_idle_pct = 37;
      stall_pct     = 37;
      for (i = 0; i < SLOTS; i++) begin
         if (i == 7) begin
            kept_key = key_for_slot(i, {$urandom, $urandom});
            send_item(ACT_INSERT, kept_key);
         end else begin
            send_item(ACT_INSERT, key_for_slot(i, {$urandom, $urandom}));
         end
      end
      send_item(ACT_INSERT, {$urandom, $urandom});
      send_item(ACT_INSERT, kept_key);
      send_item(ACT_INSERT, 64'd0);
      send_item(ACT_CLEAR, '0);

      // random traffic under each idling pattern
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         for (i = 0; i < 200; i++) begin
            // long result hold-off while requests keep coming
            if (ph == 0 && i == 20) hold_pending = 1'b1;
            send_random();
         end
      end
      req_valid <= 1'b0;
      // let the monitor note the last request transfer first
      @(posedge clock);

      // drain outstanding results, then watch for strays
      while (tracker.pending() != 0) @(posedge clock);
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
